// ===== sv/sesp_pkg.sv =====
package sesp_pkg;

    // Number of axes that keep their own enable sequence and setpoint.
    localparam int AXES = 3;
    localparam int AXIS_IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

    // Fixed field widths.
    localparam int AXIS_W     = 2;
    localparam int STATUS_W   = 16;
    localparam int POS_W      = 32;
    localparam int DIR_W      = 2;
    localparam int STEP_W     = 17;
    localparam int CTRL_W     = 16;
    localparam int MODE_W     = 8;
    localparam int MAXD_W     = 31;
    localparam int WARM_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Packed stream word widths, rounded up to whole bytes.
    localparam int S_FIELDS_W = AXIS_W + STATUS_W + POS_W + 1 + DIR_W + STEP_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = AXIS_W + CTRL_W + POS_W + MODE_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_CYCLES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPERATION_MODE = 2'd2;

    // Configuration reset values.
    localparam logic [MAXD_W-1:0] MAX_DELTA_RST = 31'd400000;
    localparam logic [WARM_W-1:0] WARMUP_RST    = 8'd10;
    localparam logic [MODE_W-1:0] MODE_RST      = 8'd8;

    // Status word decoding.
    localparam logic [STATUS_W-1:0] STATE_MASK           = 16'h006F;
    localparam logic [STATUS_W-1:0] ST_SWITCHED_ON_READY = 16'h0021;
    localparam logic [STATUS_W-1:0] ST_SWITCHED_ON       = 16'h0023;
    localparam logic [STATUS_W-1:0] ST_OP_ENABLED        = 16'h0027;

    // Control words.
    localparam logic [CTRL_W-1:0] CW_NONE      = 16'h0000;
    localparam logic [CTRL_W-1:0] CW_SHUTDOWN  = 16'h0006;
    localparam logic [CTRL_W-1:0] CW_SWITCH_ON = 16'h0007;
    localparam logic [CTRL_W-1:0] CW_ENABLE_OP = 16'h000F;

    // Step limits.
    localparam logic [STEP_W-1:0] STEP_MIN = 17'd1;
    localparam logic [STEP_W-1:0] STEP_MAX = 17'd100000;

    // Direction codes.
    localparam logic [DIR_W-1:0] DIR_FWD = 2'b01;
    localparam logic [DIR_W-1:0] DIR_REV = 2'b11;

    typedef enum logic [1:0] {
        SC_OTHER,
        SC_READY,
        SC_SWITCHED_ON,
        SC_OP_ENABLED
    } status_class_t;

    // Classified item, as it travels from the front end to the back end.
    typedef struct packed {
        logic [AXIS_W-1:0]     axis;
        logic                  axis_ok;
        logic [AXIS_IDX_W-1:0] idx;
        status_class_t         sclass;
        logic [POS_W-1:0]      actual;
        logic [POS_W-1:0]      delta;
    } item_t;

    // One finished result.
    typedef struct packed {
        logic                     enabled;
        logic signed [MODE_W-1:0] mode_out;
        logic signed [POS_W-1:0]  target_position;
        logic [CTRL_W-1:0]        control_word;
        logic [AXIS_W-1:0]        axis_out;
    } result_t;

endpackage

// ===== sv/servo_enable_and_position_setpoint.sv =====
// Drive enable sequencer and position setpoint generator for up to three
// servo axes. Each input word carries one axis' status word, actual position
// and motion command; each input word yields exactly one output word with the
// control word, target position, mode of operation and the axis' enabled
// flag. The block sustains one word per clock while the master side takes
// each result. A word is written into a two-entry queue at the edge that
// accepts it. The per-axis state unit takes the queue head, does the
// read-modify-write of that axis' registers and loads the result into the
// output register once that register is empty or its result is taken.
// While a result waits on the master side, the queue still takes two more
// words, and then s_tready drops. s_tready rises again right after the edge at
// which the waiting result is taken. Configuration writes are always accepted
// and must only be issued while no word is in flight.
module servo_enable_and_position_setpoint (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Input words.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata, lowest bit first: axis[1:0], status_word[17:2],
    // actual_position[49:18], run[50], direction[52:51], step[69:53],
    // zero fill[71:70].
    input  logic [sesp_pkg::S_TDATA_W-1:0]     s_tdata,

    // Result words.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata, lowest bit first: axis_out[1:0], control_word[17:2],
    // target_position[49:18], mode_out[57:50], enabled[58], zero fill[63:59].
    output logic [sesp_pkg::M_TDATA_W-1:0]     m_tdata,

    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sesp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sesp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sesp_pkg::*;

    // Configuration registers.
    logic [MAXD_W-1:0] max_delta_reg;
    logic [WARM_W-1:0] warmup_reg;
    logic [MODE_W-1:0] mode_reg;

    // Unpacked input fields.
    logic [AXIS_W-1:0]   in_axis;
    logic [STATUS_W-1:0] in_status;
    logic [POS_W-1:0]    in_actual;
    logic                in_run;
    logic [DIR_W-1:0]    in_dir;
    logic [STEP_W-1:0]   in_step;

    item_t   front_item;
    item_t   head_item;
    result_t res;
    logic    queue_full;
    logic    head_valid;
    logic    pop;
    logic    push;

    assign in_axis   = s_tdata[1:0];
    assign in_status = s_tdata[17:2];
    assign in_actual = s_tdata[49:18];
    assign in_run    = s_tdata[50];
    assign in_dir    = s_tdata[52:51];
    assign in_step   = s_tdata[69:53];

    assign s_tready  = !queue_full;
    assign push      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_delta_reg <= MAX_DELTA_RST;
            warmup_reg    <= WARMUP_RST;
            mode_reg      <= MODE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_DELTA:      max_delta_reg <= cfg_data[MAXD_W-1:0];
                REG_WARMUP_CYCLES:  warmup_reg    <= cfg_data[WARM_W-1:0];
                REG_OPERATION_MODE: mode_reg      <= cfg_data[MODE_W-1:0];
                default: begin
                    // Writes to unknown indexes are dropped.
                end
            endcase
        end
    end

    // The front end decodes the status word and folds run, direction, step
    // and the per-cycle limit into one signed increment.
    sesp_front u_front (
        .axis            (in_axis),
        .status_word     (in_status),
        .actual_position (in_actual),
        .run             (in_run),
        .direction       (in_dir),
        .step            (in_step),
        .max_delta       (max_delta_reg),
        .item            (front_item)
    );

    sesp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (front_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // The back end owns the per-axis state and the output register.
    sesp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .pop            (pop),
        .warmup_cycles  (warmup_reg),
        .operation_mode (mode_reg),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res            (res)
    );

    assign m_tdata = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, res};

endmodule

// ===== sv/sesp_front.sv =====
module sesp_front (
    input  logic [sesp_pkg::AXIS_W-1:0]   axis,
    input  logic [sesp_pkg::STATUS_W-1:0] status_word,
    input  logic [sesp_pkg::POS_W-1:0]    actual_position,
    input  logic                          run,
    input  logic [sesp_pkg::DIR_W-1:0]    direction,
    input  logic [sesp_pkg::STEP_W-1:0]   step,
    input  logic [sesp_pkg::MAXD_W-1:0]   max_delta,
    output sesp_pkg::item_t               item
);
    import sesp_pkg::*;

    logic [STATUS_W-1:0] masked;
    logic [STEP_W-1:0]   mag_sat;
    logic [STEP_W-1:0]   mag;
    logic                moving;

    always_comb begin
        masked = status_word & STATE_MASK;

        // Saturate the step to its legal range, then to the per-cycle limit.
        if (step < STEP_MIN) begin
            mag_sat = STEP_MIN;
        end else if (step > STEP_MAX) begin
            mag_sat = STEP_MAX;
        end else begin
            mag_sat = step;
        end
        if ({{(MAXD_W-STEP_W){1'b0}}, mag_sat} > max_delta) begin
            mag = max_delta[STEP_W-1:0];
        end else begin
            mag = mag_sat;
        end

        moving = run && (direction == DIR_FWD || direction == DIR_REV);

        item.axis    = axis;
        item.axis_ok = (32'(axis) < AXES);
        item.idx     = AXIS_IDX_W'(axis);
        item.actual  = actual_position;

        if (!moving) begin
            item.delta = '0;
        end else if (direction == DIR_REV) begin
            item.delta = POS_W'(0) - {{(POS_W-STEP_W){1'b0}}, mag};
        end else begin
            item.delta = {{(POS_W-STEP_W){1'b0}}, mag};
        end

        unique case (masked)
            ST_SWITCHED_ON_READY: item.sclass = SC_READY;
            ST_SWITCHED_ON:       item.sclass = SC_SWITCHED_ON;
            ST_OP_ENABLED:        item.sclass = SC_OP_ENABLED;
            default:              item.sclass = SC_OTHER;
        endcase
    end

endmodule

// ===== sv/sesp_queue.sv =====
module sesp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sesp_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output sesp_pkg::item_t head_item
);
    import sesp_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/sesp_back.sv =====
module sesp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  sesp_pkg::item_t               head_item,
    output logic                          pop,
    input  logic [sesp_pkg::WARM_W-1:0]   warmup_cycles,
    input  logic [sesp_pkg::MODE_W-1:0]   operation_mode,
    output logic                          res_valid,
    input  logic                          res_ready,
    output sesp_pkg::result_t             res
);
    import sesp_pkg::*;

    // Per-axis state, one entry per axis.
    logic              en_reg    [AXES];
    logic              first_reg [AXES];
    logic [WARM_W-1:0] warm_reg  [AXES];
    logic [POS_W-1:0]  sp_reg    [AXES];
    logic [POS_W-1:0]  sent_reg  [AXES];

    logic              out_valid_reg;
    result_t           out_reg;

    logic              en_next;
    logic              first_next;
    logic [WARM_W-1:0] warm_next;
    logic [POS_W-1:0]  sp_next;
    logic [POS_W-1:0]  sent_next;
    logic [CTRL_W-1:0] cw;
    result_t           out_next;

    assign pop       = head_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb begin
        en_next    = en_reg[head_item.idx];
        first_next = first_reg[head_item.idx];
        warm_next  = warm_reg[head_item.idx];
        sp_next    = sp_reg[head_item.idx];
        sent_next  = sent_reg[head_item.idx];
        cw         = CW_ENABLE_OP;

        if (!en_next) begin
            unique case (head_item.sclass)
                SC_READY: begin
                    cw        = CW_SWITCH_ON;
                    sent_next = head_item.actual;
                end
                SC_SWITCHED_ON: begin
                    cw = CW_ENABLE_OP;
                end
                SC_OP_ENABLED: begin
                    cw        = CW_ENABLE_OP;
                    en_next   = 1'b1;
                    warm_next = warmup_cycles;
                    sp_next   = head_item.actual;
                end
                default: begin
                    cw = CW_SHUTDOWN;
                end
            endcase
        end else begin
            priority if (!first_next) begin
                first_next = 1'b1;
                sp_next    = head_item.actual;
            end else if (warm_next != '0) begin
                sp_next   = head_item.actual;
                warm_next = warm_next - WARM_W'(1);
            end else begin
                sp_next = sp_next + head_item.delta;
            end
            sent_next = sp_next;
        end

        out_next.axis_out = head_item.axis;
        out_next.mode_out = operation_mode;
        if (head_item.axis_ok) begin
            out_next.control_word    = cw;
            out_next.target_position = sent_next;
            out_next.enabled         = en_next;
        end else begin
            out_next.control_word    = CW_NONE;
            out_next.target_position = '0;
            out_next.enabled         = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                en_reg[i]    <= 1'b0;
                first_reg[i] <= 1'b0;
                warm_reg[i]  <= '0;
                sp_reg[i]    <= '0;
                sent_reg[i]  <= '0;
            end
        end else begin
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (pop && head_item.axis_ok) begin
                en_reg[head_item.idx]    <= en_next;
                first_reg[head_item.idx] <= first_next;
                warm_reg[head_item.idx]  <= warm_next;
                sp_reg[head_item.idx]    <= sp_next;
                sent_reg[head_item.idx]  <= sent_next;
            end
        end
    end

endmodule
